FILE: rtl/lhpc_pkg.sv
package lhpc_pkg;

    localparam int PIXELS    = 65536;
    localparam int PIX_AW    = $clog2(PIXELS);
    localparam int CNT_W     = PIX_AW + 1;
    localparam int MAX_BINS  = 4096;
    localparam int BIN_AW    = $clog2(MAX_BINS);
    localparam int BINCNT_W  = CNT_W;
    localparam int ELEV_W    = 20;
    localparam int THR_W     = 16;
    localparam int SPAN_W    = ELEV_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W    = SPAN_W + BIN_AW + 1;

    typedef logic signed [ELEV_W-1:0] t_elev;

    localparam logic [CFG_IDX_W-1:0] CFG_GROUND_THR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VEG_DIFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLD_DIFF   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_BLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VEG    = 3'd4;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

endpackage

FILE: rtl/lidar_height_pixel_classifier_core.sv
// Pixel loads without the final mark are taken back to back and give no result. A query
// passes through S_QRD and S_QEV and then registers its labels once the output is free.
// A final load runs the histogram, unless the bin count is zero: a clearing sweep of the bins,
// a pass over the loaded pixels (store read, 13-step divider, bin update) and a peak search;
// the report is then registered once the output is free. No request is taken until idle.
// Reset (synchronous, active low) restores thresholds, clears extremes, ground and count.
module lidar_height_pixel_classifier_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lhpc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lhpc_pkg::THR_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic signed [19:0]            i_first_return,
    input  logic signed [19:0]            i_last_return,
    input  logic                          i_final_pixel,
    input  logic [15:0]                   i_pixel_index,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic                          o_result_kind,
    output logic signed [19:0]            o_ground_level,
    output logic                          o_ground_flag,
    output logic                          o_vegetation_flag,
    output logic                          o_building_flag,
    output logic                          o_index_error
);
    import lhpc_pkg::*;

    // The sequencer: idle, query read, query evaluate, histogram phases, report.
    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_QRD   = 9'b000000010,
        S_QEV   = 9'b000000100,
        S_CLR   = 9'b000001000,
        S_HRD   = 9'b000010000,
        S_HDIV  = 9'b000100000,
        S_HINC  = 9'b001000000,
        S_PEAK  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state r_state;

    logic [THR_W-1:0] r_gthr, r_vdiff, r_bdiff, r_minb, r_maxv;
    t_elev            r_min, r_max, r_ground;
    logic [CNT_W-1:0] r_count;
    logic             r_done;

    // Output register.
    logic             r_ovalid, r_okind, r_og, r_ov, r_ob, r_oerr;
    t_elev            r_olevel;

    // Working registers.
    logic [CNT_W-1:0]    r_i;
    logic [BIN_AW:0]     r_nbins;
    logic [SPAN_W-1:0]   r_span;
    logic [PROD_W-1:0]   r_rem;
    logic [BIN_AW:0]     r_quot;
    logic [5:0]          r_dstep;
    logic [BINCNT_W-1:0] r_best_cnt;
    logic [BIN_AW-1:0]   r_best;
    logic                r_found;
    logic                r_qerr;
    logic                r_peak_rd;
    logic [BIN_AW-1:0]   r_peak_idx;

    // Store ports.
    logic              st_we;
    logic [PIX_AW-1:0] st_waddr, st_raddr;
    t_elev             st_f_wd, st_l_wd, st_f_rd, st_l_rd;

    // Bin memory ports.
    logic                bn_we;
    logic [BIN_AW-1:0]   bn_waddr, bn_raddr;
    logic [BINCNT_W-1:0] bn_wd, bn_rd;

    lhpc_ram #(.WIDTH(ELEV_W), .DEPTH(PIXELS)) u_first (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_f_wd),
        .i_raddr(st_raddr), .o_rdata(st_f_rd));
    lhpc_ram #(.WIDTH(ELEV_W), .DEPTH(PIXELS)) u_last (
        .i_clk(i_clk), .i_we(st_we), .i_waddr(st_waddr), .i_wdata(st_l_wd),
        .i_raddr(st_raddr), .o_rdata(st_l_rd));
    lhpc_ram #(.WIDTH(BINCNT_W), .DEPTH(MAX_BINS)) u_bins (
        .i_clk(i_clk), .i_we(bn_we), .i_waddr(bn_waddr), .i_wdata(bn_wd),
        .i_raddr(bn_raddr), .o_rdata(bn_rd));

    // A result waiting in the output register does not block the input; only a query
    // or a final load that reaches the output stage waits for it there.
    logic acc;
    assign o_ready = (r_state == S_IDLE);
    assign acc     = i_valid && o_ready;

    // Load datapath: swap and figure the effective count after a new frame begins.
    t_elev            ld_f, ld_l;
    logic [CNT_W-1:0] eff_cnt;
    logic             room;
    assign ld_f    = (i_first_return < i_last_return) ? i_last_return : i_first_return;
    assign ld_l    = (i_first_return < i_last_return) ? i_first_return : i_last_return;
    assign eff_cnt = r_done ? '0 : r_count;
    assign room    = eff_cnt < CNT_W'(PIXELS);

    t_elev new_min, new_max;
    always_comb begin
        new_min = r_min;
        new_max = r_max;
        if (room) begin
            if (eff_cnt == '0) begin
                new_min = ld_l;
                new_max = ld_f;
            end else begin
                if (ld_f > r_max) new_max = ld_f;
                if (ld_l < r_min) new_min = ld_l;
            end
        end
    end

    // Span and bin count of the finished load.
    logic [SPAN_W-1:0] nspan;
    logic [SPAN_W-3:0] nb_raw;
    logic [BIN_AW:0]   nb_sat;
    assign nspan  = SPAN_W'($signed({new_max[ELEV_W-1], new_max})
                          - $signed({new_min[ELEV_W-1], new_min}));
    assign nb_raw = (SPAN_W-2)'((nspan + SPAN_W'(7)) >> 3);
    assign nb_sat = (nb_raw > (SPAN_W-2)'(MAX_BINS)) ? (BIN_AW+1)'(MAX_BINS)
                                                       : (BIN_AW+1)'(nb_raw);

    // Histogram offset of the stored last return; it never falls below min.
    logic [SPAN_W-1:0] off;
    assign off = SPAN_W'($signed({st_l_rd[ELEV_W-1], st_l_rd})
                       - $signed({r_min[ELEV_W-1], r_min}));

    // Restoring divider: one quotient bit per cycle of off*nbins / span.
    logic [PROD_W-1:0] trial;
    logic [PROD_W-1:0] sh_span;
    logic              take;
    logic [BIN_AW:0]   quot_nx;
    assign sh_span = PROD_W'(r_span) << (r_dstep);
    assign trial   = r_rem - sh_span;
    assign take    = r_rem >= sh_span;
    assign quot_nx = take ? (r_quot | ((BIN_AW+1)'(1) << r_dstep)) : r_quot;

    // Bin index clamped to the top bin; the read is issued on the last divider step
    // with the quotient as it will stand after that step.
    logic [BIN_AW-1:0] bin_idx, bin_nx;
    assign bin_idx = (r_quot > r_nbins - 1'b1) ? BIN_AW'(r_nbins - 1'b1) : BIN_AW'(r_quot);
    assign bin_nx  = (quot_nx > r_nbins - 1'b1) ? BIN_AW'(r_nbins - 1'b1) : BIN_AW'(quot_nx);

    // Query evaluation on the registered store data.
    logic signed [ELEV_W+1:0] qf, ql, qg, qdiff;
    logic q_g, q_v, q_b;
    assign qf    = (ELEV_W+2)'(st_f_rd);
    assign ql    = (ELEV_W+2)'(st_l_rd);
    assign qg    = (ELEV_W+2)'(r_ground);
    assign qdiff = qf - ql;
    always_comb begin
        q_g = ql <= qg + $signed({6'd0, r_gthr});
        q_v = !q_g && (qdiff > $signed({6'd0, r_vdiff}));
        q_b = !q_g && (((qdiff < $signed({6'd0, r_bdiff})) && (qf > qg + $signed({6'd0, r_minb})))
                       || (qf > qg + $signed({6'd0, r_maxv})));
    end

    always_comb begin
        st_we    = acc && (i_kind == KIND_LOAD) && room;
        st_waddr = PIX_AW'(eff_cnt);
        st_f_wd  = ld_f;
        st_l_wd  = ld_l;
        st_raddr = (r_state == S_IDLE) ? i_pixel_index[PIX_AW-1:0] : PIX_AW'(r_i);
        bn_we    = 1'b0;
        bn_waddr = r_peak_idx;
        bn_wd    = '0;
        bn_raddr = r_peak_idx;
        case (r_state)
            S_CLR: begin
                bn_we = 1'b1;
            end
            S_HDIV: begin
                bn_raddr = bin_nx;
            end
            S_HINC: begin
                // Fetch the next pixel so that it is ready when the pass returns to S_HRD.
                st_raddr = PIX_AW'(r_i + 1'b1);
                bn_we    = 1'b1;
                bn_waddr = bin_idx;
                bn_wd    = bn_rd + 1'b1;
            end
            default: begin
            end
        endcase
    end

    function automatic logic nb_sat_keep();
        return r_nbins != '0;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_gthr   <= THR_W'(16);
            r_vdiff  <= THR_W'(12);
            r_bdiff  <= THR_W'(8);
            r_minb   <= THR_W'(40);
            r_maxv   <= THR_W'(160);
            r_min    <= '0;
            r_max    <= '0;
            r_ground <= '0;
            r_count  <= '0;
            r_done   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_GROUND_THR: r_gthr  <= i_cfg_data;
                    CFG_VEG_DIFF:   r_vdiff <= i_cfg_data;
                    CFG_BLD_DIFF:   r_bdiff <= i_cfg_data;
                    CFG_MIN_BLD:    r_minb  <= i_cfg_data;
                    CFG_MAX_VEG:    r_maxv  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (acc && i_kind == KIND_LOAD) begin
                        r_min <= new_min;
                        r_max <= new_max;
                        r_count <= room ? eff_cnt + 1'b1 : eff_cnt;
                        r_done <= i_final_pixel;
                        if (i_final_pixel) begin
                            r_span     <= nspan;
                            r_nbins    <= nb_sat;
                            r_i        <= '0;
                            r_peak_idx <= '0;
                            r_best     <= '0;
                            r_best_cnt <= '0;
                            r_found    <= 1'b0;
                            if (nb_sat == '0) begin
                                r_ground <= '0;
                                r_state  <= S_OUT;
                            end else begin
                                r_state <= S_CLR;
                            end
                        end
                    end else if (acc) begin
                        // The index is held so that the store read stays on the queried pixel.
                        r_i     <= CNT_W'(i_pixel_index);
                        r_qerr  <= {1'b0, i_pixel_index} >= r_count;
                        r_state <= S_QRD;
                    end
                end
                S_QRD: r_state <= S_QEV;
                S_QEV: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_QUERY;
                        r_olevel <= r_ground;
                        r_oerr   <= r_qerr;
                        r_og     <= !r_qerr && q_g;
                        r_ov     <= !r_qerr && q_v;
                        r_ob     <= !r_qerr && q_b;
                        r_state  <= S_IDLE;
                    end
                end
                S_CLR: begin
                    r_peak_idx <= r_peak_idx + 1'b1;
                    if ((BIN_AW+1)'(r_peak_idx) == r_nbins - 1'b1) begin
                        r_peak_idx <= '0;
                        r_state    <= S_HRD;
                    end
                end
                S_HRD: begin
                    // Store read of pixel r_i issued last cycle is now at st_l_rd.
                    if (r_i == r_count) begin
                        r_peak_rd <= 1'b0;
                        r_state   <= S_PEAK;
                    end else begin
                        r_rem   <= PROD_W'(off) * PROD_W'(r_nbins);
                        r_quot  <= '0;
                        r_dstep <= 6'(BIN_AW);
                        r_state <= S_HDIV;
                    end
                end
                S_HDIV: begin
                    if (take) begin
                        r_rem  <= trial;
                        r_quot <= quot_nx;
                    end
                    if (r_dstep == '0) r_state <= S_HINC;
                    else r_dstep <= r_dstep - 1'b1;
                end
                S_HINC: begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_HRD;
                end
                S_PEAK: begin
                    // Pipelined scan: address r_peak_idx, compare the data from one back.
                    r_peak_rd <= 1'b1;
                    if (r_peak_rd && bn_rd > r_best_cnt) begin
                        r_best_cnt <= bn_rd;
                        r_best     <= r_peak_idx - 1'b1;
                        r_found    <= 1'b1;
                    end
                    if ((BIN_AW+1)'(r_peak_idx) == r_nbins || (r_peak_rd && r_peak_idx == '0))
                    begin
                        r_state <= S_OUT;
                    end else begin
                        r_peak_idx <= r_peak_idx + 1'b1;
                    end
                end
                S_OUT: begin
                    if (!r_ovalid) begin
                        r_ovalid <= 1'b1;
                        r_okind  <= KIND_LOAD;
                        r_olevel <= (nb_sat_keep() && r_found)
                                    ? ELEV_W'(r_min + ELEV_W'({r_best, 3'd0})) : '0;
                        if (nb_sat_keep() && r_found)
                            r_ground <= ELEV_W'(r_min + ELEV_W'({r_best, 3'd0}));
                        else
                            r_ground <= '0;
                        r_og <= 1'b0; r_ov <= 1'b0; r_ob <= 1'b0; r_oerr <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid           = r_ovalid;
    assign o_result_kind     = r_okind;
    assign o_ground_level    = r_olevel;
    assign o_ground_flag     = r_og;
    assign o_vegetation_flag = r_ov;
    assign o_building_flag   = r_ob;
    assign o_index_error     = r_oerr;

    a_one_flag_ground: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_ground_flag |-> !o_vegetation_flag && !o_building_flag)
        else $error("ground pixel also carries another label");
    a_err_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_index_error |-> !o_ground_flag && !o_vegetation_flag && !o_building_flag)
        else $error("index error with a label set");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != S_IDLE |-> !o_ready)
        else $error("ready while busy");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(PIXELS))
        else $error("loaded count beyond store depth");
endmodule

FILE: rtl/lhpc_ram.sv
module lhpc_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: tb/sv/lidar_height_pixel_classifier_core_tb.sv
`timescale 1ns / 1ps

module lidar_height_pixel_classifier_core_tb;
    import lhpc_pkg::*;

    // One request toward the classifier: a pixel load or a label query.
    typedef struct {
        logic               kind;
        logic signed [19:0] first_elev;
        logic signed [19:0] last_elev;
        logic               final_pix;
        logic [15:0]        pix_idx;
    } t_request;

    // One expected report or label set.
    typedef struct {
        logic               kind;
        logic signed [19:0] ground;
        logic               gnd;
        logic               veg;
        logic               bld;
        logic               ierr;
    } t_labels;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [THR_W-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    logic o_ready;
    logic i_kind = 1'b0;
    logic signed [19:0] i_first_return = '0;
    logic signed [19:0] i_last_return = '0;
    logic i_final_pixel = 1'b0;
    logic [15:0] i_pixel_index = '0;
    logic o_valid;
    logic i_ready = 1'b0;
    logic o_result_kind;
    logic signed [19:0] o_ground_level;
    logic o_ground_flag, o_vegetation_flag, o_building_flag, o_index_error;

    lidar_height_pixel_classifier_core dut (.*);

    always #5 i_clk = ~i_clk;

    // Shadow of the classifier state, used to work out each expected result.
    logic [15:0] thr_ground, thr_veg_diff, thr_bld_diff, thr_min_bld, thr_max_veg;
    logic signed [19:0] shadow_first [0:PIXELS-1];
    logic signed [19:0] shadow_last  [0:PIXELS-1];
    int unsigned hist [0:MAX_BINS-1];
    logic signed [19:0] lo_elev, hi_elev, ground_est;
    int unsigned pix_count;
    bit frame_closed;

    t_request pending_requests [$];
    t_labels  expected_labels [$];
    int       error_count = 0;
    bit       stim_done = 1'b0;
    bit       hold_off = 1'b0;   // long receiver stall, set by the stimulus process

    task automatic report_mismatch(input string what);
        $display("mismatch: %s at %0t", what, $realtime);
        error_count++;
    endtask

    // Earliest peak of the last-return histogram, offset from the minimum.
    function automatic logic signed [19:0] ground_from_histogram();
        longint span, nbins, off, idx;
        int unsigned peak_bin, peak_count;
        bit seen;
        span = longint'(hi_elev) - longint'(lo_elev);
        nbins = (span + 7) / 8;
        if (nbins > MAX_BINS) nbins = MAX_BINS;
        if (nbins == 0 || pix_count == 0) return '0;
        for (int b = 0; b < MAX_BINS; b++) hist[b] = 0;
        for (int p = 0; p < pix_count; p++) begin
            off = longint'(shadow_last[p]) - longint'(lo_elev);
            if (off < 0) off = 0;
            idx = (off * nbins) / span;
            if (idx > nbins - 1) idx = nbins - 1;
            hist[idx]++;
        end
        peak_bin = 0; peak_count = 0; seen = 0;
        for (int b = 0; b < nbins; b++) begin
            if (hist[b] > peak_count) begin
                peak_count = hist[b]; peak_bin = b; seen = 1;
            end
        end
        return seen ? 20'(longint'(lo_elev) + 8 * longint'(peak_bin)) : 20'sd0;
    endfunction

    // Applies one accepted request to the shadow state; returns 1 with a result.
    function automatic bit classify_request(input t_request r, output t_labels res);
        logic signed [19:0] f, l;
        longint g, diff, fl, ll;
        res = '{kind: r.kind, ground: ground_est, gnd: 0, veg: 0, bld: 0, ierr: 0};
        if (r.kind == KIND_LOAD) begin
            if (frame_closed) begin
                pix_count = 0; frame_closed = 0;
            end
            f = r.first_elev; l = r.last_elev;
            if (f < l) begin
                f = r.last_elev; l = r.first_elev;
            end
            if (pix_count < PIXELS) begin
                if (pix_count == 0) begin
                    lo_elev = l; hi_elev = f;
                end else begin
                    if (f > hi_elev) hi_elev = f;
                    if (l < lo_elev) lo_elev = l;
                end
                shadow_first[pix_count] = f;
                shadow_last[pix_count] = l;
                pix_count++;
            end
            if (!r.final_pix) return 0;
            ground_est = ground_from_histogram();
            frame_closed = 1;
            res.ground = ground_est;
            return 1;
        end
        if (r.pix_idx >= pix_count) begin
            res.ierr = 1;
            return 1;
        end
        f = shadow_first[r.pix_idx];
        l = shadow_last[r.pix_idx];
        fl = longint'(f);
        ll = longint'(l);
        g = ground_est;
        diff = fl - ll;
        if (ll <= g + longint'(thr_ground)) begin
            res.gnd = 1;
        end else begin
            res.veg = diff > longint'(thr_veg_diff);
            res.bld = (diff < longint'(thr_bld_diff) && fl > g + longint'(thr_min_bld))
                      || fl > g + longint'(thr_max_veg);
        end
        return 1;
    endfunction

    // Driver: bursts of offers with random gaps; payload held until the transfer.
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        t_labels res;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                if (classify_request(pending_requests[0], res)) expected_labels.push_back(res);
                void'(pending_requests.pop_front());
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_valid <= 1'b0;
                end else if ((i_valid && o_ready ? pending_requests.size() > 0
                                                 : pending_requests.size() > 0)) begin
                    i_valid <= 1'b1;
                    i_kind <= pending_requests[0].kind;
                    i_first_return <= pending_requests[0].first_elev;
                    i_last_return <= pending_requests[0].last_elev;
                    i_final_pixel <= pending_requests[0].final_pix;
                    i_pixel_index <= pending_requests[0].pix_idx;
                    if (burst_left > 0) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(0, 30);
                        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: its own stall pattern, plus the long hold-off on request.
    int stall_phase = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (expected_labels.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    t_labels e;
                    e = expected_labels.pop_front();
                    if (o_result_kind !== e.kind) report_mismatch("result_kind");
                    if (o_ground_level !== e.ground) report_mismatch("ground_level");
                    if (o_ground_flag !== e.gnd) report_mismatch("ground_flag");
                    if (o_vegetation_flag !== e.veg) report_mismatch("vegetation_flag");
                    if (o_building_flag !== e.bld) report_mismatch("building_flag");
                    if (o_index_error !== e.ierr) report_mismatch("index_error");
                end
            end
            stall_phase <= (stall_phase + 1) % 23;
            if (hold_off) i_ready <= 1'b0;
            else if (stall_phase < 8) i_ready <= 1'b1;
            else i_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    task automatic queue_load(input logic signed [19:0] f, input logic signed [19:0] l,
                              input logic fin);
        pending_requests.push_back('{kind: KIND_LOAD, first_elev: f, last_elev: l,
                                     final_pix: fin, pix_idx: 16'($urandom)});
    endtask

    task automatic queue_query(input logic [15:0] idx);
        pending_requests.push_back('{kind: KIND_QUERY, first_elev: 20'($urandom),
                                     last_elev: 20'($urandom),
                                     final_pix: 1'($urandom_range(0, 1)), pix_idx: idx});
    endtask

    // Waits until every queued request went through and every result came back.
    // The extra cycles cover a trailing load that gives no result.
    task automatic drain();
        while (pending_requests.size() > 0 || i_valid || expected_labels.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        case (idx)
            CFG_GROUND_THR: thr_ground = val;
            CFG_VEG_DIFF:   thr_veg_diff = val;
            CFG_BLD_DIFF:   thr_bld_diff = val;
            CFG_MIN_BLD:    thr_min_bld = val;
            default:        thr_max_veg = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 200));
        endcase
    endfunction

    function automatic logic signed [19:0] pick_elev(input logic signed [19:0] base,
                                                    input int spread);
        case ($urandom_range(0, 19))
            0: return 20'sh80000;
            1: return 20'sh7FFFF;
            2: return 20'($urandom);
            default: return base + 20'($urandom_range(0, spread)) - 20'(spread / 2);
        endcase
    endfunction

    initial begin
        int frame_len, spread, sent, nq;
        logic signed [19:0] base;
        thr_ground = 16; thr_veg_diff = 12; thr_bld_diff = 8;
        thr_min_bld = 40; thr_max_veg = 160;
        lo_elev = '0; hi_elev = '0; ground_est = '0; pix_count = 0; frame_closed = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: queries before any load, a flat frame (span zero), a swapped
        // pair, the elevation extremes, out-of-range indexes, and a new frame.
        queue_query(16'd0);
        queue_query(16'hFFFF);
        queue_load(20'sd100, 20'sd100, 1'b1);
        queue_query(16'd0);
        queue_query(16'd1);
        queue_load(20'sd50, 20'sd200, 1'b0);
        queue_load(20'sh7FFFF, 20'sh80000, 1'b0);
        queue_load(20'sd10, 20'sd0, 1'b0);
        queue_load(20'sd300, 20'sd12, 1'b1);
        for (int q = 0; q < 5; q++) queue_query(16'(q));
        queue_query(16'hFFFF);
        queue_load(20'sd0, 20'sd0, 1'b0);
        queue_load(20'sd64, 20'sd4, 1'b0);
        queue_load(20'sd40, 20'sd0, 1'b1);
        for (int q = 0; q < 3; q++) queue_query(16'(q));
        drain();

        // Extreme settings first, then random ones; every register gets written.
        for (int phase = 0; phase < 6; phase++) begin
            for (int r = 0; r < 5; r++)
                write_reg(3'(r), phase == 0 ? 16'h0000 : phase == 1 ? 16'hFFFF
                                                       : pick_threshold());
            sent = 0;
            while (sent < 170) begin
                // Mostly small frames with clustered elevations and random queries.
                frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                        : $urandom_range(1, 8);
                spread = ($urandom_range(0, 4) == 0) ? 4000 : $urandom_range(0, 300);
                base = 20'($urandom_range(0, 4000)) - 20'sd2000;
                for (int p = 0; p < frame_len; p++)
                    queue_load(pick_elev(base, spread), pick_elev(base, spread),
                               p == frame_len - 1 ? 1'b1 : ($urandom_range(0, 30) == 0));
                nq = $urandom_range(1, 12);
                for (int q = 0; q < nq; q++)
                    queue_query($urandom_range(0, 3) == 0 ? 16'($urandom)
                                                          : 16'($urandom_range(0, frame_len)));
                sent += frame_len + nq;
                if (phase == 2 && sent == frame_len + nq) begin
                    // Long receiver hold-off while the sender keeps offering.
                    for (int q = 0; q < 40; q++) queue_query(16'($urandom_range(0, 3)));
                    hold_off = 1'b1;
                    repeat (300) @(posedge i_clk);
                    hold_off = 1'b0;
                end
            end
            drain();
        end
        stim_done = 1'b1;
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && expected_labels.size() == 0) begin
            $display("lidar_height_pixel_classifier_core_tb: PASS");
        end else begin
            $display("lidar_height_pixel_classifier_core_tb: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #200ms;
        $display("lidar_height_pixel_classifier_core_tb: FAIL");
        $finish;
    end

endmodule
